// ----- hdl/c3ksf_pkg.sv -----
package c3ksf_pkg;

    // Pixel and channel geometry
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PX_W       = CH_W * NUM_CH;
    localparam int WIN_N      = 9;
    localparam int WIN_CENTRE = 4;

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int KSEL_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int DIM_RESET = 1024;

    // Result position width
    localparam int POS_W = 10;

    // Default buffer geometry
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Arithmetic: kernel sums stay within +/-4095
    localparam int SUM_W      = 13;
    localparam int POST_W     = 14;
    localparam int PROD_W     = 25;
    localparam int DIV9_RECIP = 7282;   // ceil(2^16 / 9), exact for sums up to 2295
    localparam int DIV9_SHIFT = 16;
    localparam int WGT_SHIFT  = 4;
    localparam int BIAS       = 100;
    localparam int PIX_MAX    = 255;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KSEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RXS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RXE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RYS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RYE    = 3'd6;

    // Kernel selections
    localparam logic [KSEL_W-1:0] KS_BOX      = 4'd0;
    localparam logic [KSEL_W-1:0] KS_WEIGHTED = 4'd1;
    localparam logic [KSEL_W-1:0] KS_LAP4     = 4'd2;
    localparam logic [KSEL_W-1:0] KS_LAP8     = 4'd3;
    localparam logic [KSEL_W-1:0] KS_ENH4     = 4'd4;
    localparam logic [KSEL_W-1:0] KS_ENH8     = 4'd5;
    localparam logic [KSEL_W-1:0] KS_ROBERTS  = 4'd6;
    localparam logic [KSEL_W-1:0] KS_ROB_DIAG = 4'd7;
    localparam logic [KSEL_W-1:0] KS_SOBEL_X  = 4'd8;
    localparam logic [KSEL_W-1:0] KS_SOBEL_Y  = 4'd9;

    typedef logic signed [4:0]        t_coef;
    typedef t_coef [0:WIN_N-1]        t_kern;
    typedef logic [0:WIN_N-1][CH_W-1:0] t_win_chan;

    typedef struct packed {
        logic              ld_sum;
        logic              ld_out;
        logic              in_roi;
        logic [KSEL_W-1:0] sel;
    } t_chan_ctl;

    localparam t_coef K0  = 5'sd0;
    localparam t_coef KP1 = 5'sd1;
    localparam t_coef KN1 = -5'sd1;
    localparam t_coef KP2 = 5'sd2;
    localparam t_coef KN2 = -5'sd2;
    localparam t_coef KP4 = 5'sd4;
    localparam t_coef KP5 = 5'sd5;
    localparam t_coef KP8 = 5'sd8;
    localparam t_coef KP9 = 5'sd9;

    // Coefficients in window order: row-major, top-left first
    function automatic t_kern kern_row(input logic [KSEL_W-1:0] sel);
        t_kern k;
        case (sel)
            KS_BOX:      k = '{KP1, KP1, KP1, KP1, KP1, KP1, KP1, KP1, KP1};
            KS_WEIGHTED: k = '{KP1, KP2, KP1, KP2, KP4, KP2, KP1, KP2, KP1};
            KS_LAP4:     k = '{K0,  KN1, K0,  KN1, KP4, KN1, K0,  KN1, K0 };
            KS_LAP8:     k = '{KN1, KN1, KN1, KN1, KP8, KN1, KN1, KN1, KN1};
            KS_ENH4:     k = '{K0,  KN1, K0,  KN1, KP5, KN1, K0,  KN1, K0 };
            KS_ENH8:     k = '{KN1, KN1, KN1, KN1, KP9, KN1, KN1, KN1, KN1};
            KS_ROBERTS:  k = '{K0,  K0,  K0,  K0,  K0,  KN1, K0,  KP1, K0 };
            KS_ROB_DIAG: k = '{K0,  K0,  K0,  K0,  KN1, K0,  K0,  K0,  KP1};
            KS_SOBEL_X:  k = '{KN1, K0,  KP1, KN2, K0,  KP2, KN1, K0,  KP1};
            KS_SOBEL_Y:  k = '{KN1, KN2, KN1, K0,  K0,  K0,  KP1, KP2, KP1};
            default:     k = '{K0,  K0,  K0,  K0,  K0,  K0,  K0,  K0,  K0 };
        endcase
        return k;
    endfunction

    function automatic logic signed [SUM_W-1:0] kern_sum(
        input logic [KSEL_W-1:0] sel,
        input t_win_chan         win
    );
        t_kern                    k;
        logic signed [SUM_W-1:0]  acc;
        logic signed [SUM_W-1:0]  kx;
        logic signed [SUM_W-1:0]  px;
        k   = kern_row(sel);
        acc = '0;
        for (int i = 0; i < WIN_N; i++) begin
            kx  = SUM_W'(k[i]);
            px  = SUM_W'({1'b0, win[i]});
            acc = acc + kx * px;
        end
        return acc;
    endfunction

endpackage

// ----- hdl/c3ksf_line_buf.sv -----
module c3ksf_line_buf #(
    parameter int DEPTH = c3ksf_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [c3ksf_pkg::PX_W-1:0] i_wr_up,
    input  logic [c3ksf_pkg::PX_W-1:0] i_wr_mid,
    output logic [c3ksf_pkg::PX_W-1:0] o_rd_up,
    output logic [c3ksf_pkg::PX_W-1:0] o_rd_mid
);
    import c3ksf_pkg::*;

    logic [PX_W-1:0] r_upper_mem  [DEPTH];
    logic [PX_W-1:0] r_middle_mem [DEPTH];
    logic [PX_W-1:0] r_rd_up;
    logic [PX_W-1:0] r_rd_mid;
    logic            bypass;

    // Same column written and read on one edge: hand the new data straight over
    assign bypass = i_wr_en && (i_wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_upper_mem[i_wr_addr]  <= i_wr_up;
            r_middle_mem[i_wr_addr] <= i_wr_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (bypass) begin
                r_rd_up  <= i_wr_up;
                r_rd_mid <= i_wr_mid;
            end else begin
                r_rd_up  <= r_upper_mem[i_rd_addr];
                r_rd_mid <= r_middle_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_up  = r_rd_up;
    assign o_rd_mid = r_rd_mid;

endmodule

// ----- hdl/c3ksf_chan.sv -----
module c3ksf_chan (
    input  logic                       i_clk,
    input  c3ksf_pkg::t_chan_ctl       i_ctl,
    input  c3ksf_pkg::t_win_chan       i_win,
    output logic [c3ksf_pkg::CH_W-1:0] o_pix
);
    import c3ksf_pkg::*;

    logic signed [SUM_W-1:0]  r_sum;
    logic [CH_W-1:0]          r_cen;
    logic [KSEL_W-1:0]        r_sel;
    logic                     r_in;
    logic [CH_W-1:0]          r_pix;
    logic [CH_W-1:0]          n_pix;

    logic [PROD_W-1:0]        prod;
    logic signed [POST_W-1:0] q;
    logic signed [POST_W-1:0] adj;
    logic [CH_W-1:0]          sat;

    // Sum stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_sum) begin
            r_sum <= kern_sum(i_ctl.sel, i_win);
            r_cen <= i_win[WIN_CENTRE];
            r_sel <= i_ctl.sel;
            r_in  <= i_ctl.in_roi;
        end
    end

    // Scale, bias or magnitude, saturate
    assign prod = PROD_W'(r_sum[SUM_W-2:0]) * PROD_W'(DIV9_RECIP);

    always_comb begin
        case (r_sel)
            KS_BOX:      q = POST_W'(prod >> DIV9_SHIFT);
            KS_WEIGHTED: q = POST_W'(r_sum >>> WGT_SHIFT);
            default:     q = POST_W'(r_sum);
        endcase
        if (r_sel > KS_ENH8) begin
            adj = (q < 0) ? -q : q;
        end else begin
            adj = q + POST_W'(BIAS);
        end
        if (adj < 0) begin
            sat = '0;
        end else if (adj > POST_W'(PIX_MAX)) begin
            sat = CH_W'(PIX_MAX);
        end else begin
            sat = adj[CH_W-1:0];
        end
        n_pix = r_in ? sat : r_cen;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_out) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

// ----- hdl/conv3x3_kernel_select_filter_core.sv -----
// 3x3 kernel filter over an RGB raster stream. Pixels arrive one per transfer in
// raster order; frame_start on a pixel puts it at column 0, row 0. Two line buffers
// (one read and one write port each, MAX_WIDTH entries of 24 bits) keep the previous
// two rows and a 3x3 window slides along them. From column 2 and row 2 onward each
// input pixel yields one result: the window centre, one column left and one row up,
// with its position. A centre strictly inside the region of interest (start < c and
// c + 1 < end on both axes, kernel_select 0..9) has each channel filtered by the
// selected kernel: 0 box/9, 1 weighted/16, 2-3 Laplacian, 4-5 enhance (0-5 add 100),
// 6-7 Roberts, 8 Sobel X, 9 Sobel Y (these take the magnitude); the result saturates to
// 0..255 and was_filtered is 1. Other centres pass through unchanged. Columns wrap at
// image_width or MAX_WIDTH, rows likewise at image_height or MAX_HEIGHT. Throughput is
// one pixel per clock while the output is not stalled. The transfer edge reads the line
// buffer, then come window shift, kernel sum, and scale and saturate into the output
// register. Every stage moves into a free slot, so bubbles are squeezed out and input
// stall rises only once the whole pipeline is full behind a stalled output. Line
// buffers need no clearing; write registers only while the block is idle.
module conv3x3_kernel_select_filter_core #(
    parameter int MAX_WIDTH  = c3ksf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c3ksf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [c3ksf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [c3ksf_pkg::CFG_W-1:0]     i_cfg_wdata,
    // pixel input
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [c3ksf_pkg::CH_W-1:0]      i_pixel_red,
    input  logic [c3ksf_pkg::CH_W-1:0]      i_pixel_green,
    input  logic [c3ksf_pkg::CH_W-1:0]      i_pixel_blue,
    input  logic                            i_frame_start,
    // result output
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [c3ksf_pkg::CH_W-1:0]      o_out_red,
    output logic [c3ksf_pkg::CH_W-1:0]      o_out_green,
    output logic [c3ksf_pkg::CH_W-1:0]      o_out_blue,
    output logic [c3ksf_pkg::POS_W-1:0]     o_centre_x,
    output logic [c3ksf_pkg::POS_W-1:0]     o_centre_y,
    output logic                            o_was_filtered
);
    import c3ksf_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int DW = (XW > YW) ? XW : YW;
    // compare width: holds any position or register value plus one without wrap
    localparam int CW = ((DW > CFG_W) ? DW : CFG_W) + 1;

    // ---------------- configuration registers ----------------
    logic [KSEL_W-1:0] r_ksel;
    logic [CFG_W-1:0]  r_width;
    logic [CFG_W-1:0]  r_height;
    logic [CFG_W-1:0]  r_rxs;
    logic [CFG_W-1:0]  r_rxe;
    logic [CFG_W-1:0]  r_rys;
    logic [CFG_W-1:0]  r_rye;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksel   <= KS_BOX;
            r_width  <= CFG_W'(DIM_RESET);
            r_height <= CFG_W'(DIM_RESET);
            r_rxs    <= '0;
            r_rxe    <= CFG_W'(DIM_RESET);
            r_rys    <= '0;
            r_rye    <= CFG_W'(DIM_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KSEL:   r_ksel   <= i_cfg_wdata[KSEL_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_wdata;
                CFG_HEIGHT: r_height <= i_cfg_wdata;
                CFG_RXS:    r_rxs    <= i_cfg_wdata;
                CFG_RXE:    r_rxe    <= i_cfg_wdata;
                CFG_RYS:    r_rys    <= i_cfg_wdata;
                CFG_RYE:    r_rye    <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    // s1: line-buffer read data, s2: window, s3: kernel sums, then output register
    logic r_v1, r_v2, r_v3, r_vo;
    logic adv1, adv2, adv3, out_take, in_xfer;

    assign out_take = r_vo & ~i_stall;
    assign adv3     = r_v3 & (~r_vo | out_take);
    assign adv2     = r_v2 & (~r_v3 | adv3);
    // s1 moves only when s2 is free or leaving: the window shift would disturb s2's sum
    assign adv1     = r_v1 & (~r_v2 | adv2);
    assign o_stall  = r_v1 & ~adv1;
    assign in_xfer  = i_valid & ~o_stall;

    // ---------------- position counters ----------------
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;
    logic [XW-1:0] x_in;
    logic [YW-1:0] y_in;
    logic          col_last, row_last, emit_in;

    assign x_in     = i_frame_start ? '0 : r_col;
    assign y_in     = i_frame_start ? '0 : r_row;
    assign col_last = (CW'(x_in) + CW'(1) >= CW'(r_width)) || (x_in >= XW'(MAX_WIDTH - 1));
    assign row_last = (CW'(y_in) + CW'(1) >= CW'(r_height)) || (y_in >= YW'(MAX_HEIGHT - 1));
    assign emit_in  = (x_in >= XW'(2)) && (y_in >= YW'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_xfer) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : y_in + YW'(1);
            end else begin
                r_col <= x_in + XW'(1);
                r_row <= y_in;
            end
        end
    end

    // ---------------- stage 1 ----------------
    logic [XW-1:0]   r_x1;
    logic [YW-1:0]   r_y1;
    logic [PX_W-1:0] r_px1;
    logic            r_emit1;
    logic [PX_W-1:0] lb_up, lb_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (in_xfer) begin
            r_v1 <= 1'b1;
        end else if (adv1) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x1    <= x_in;
            r_y1    <= y_in;
            r_px1   <= {i_pixel_red, i_pixel_green, i_pixel_blue};
            r_emit1 <= emit_in;
        end
    end

    // Column shifts up one row as the pixel leaves s1
    c3ksf_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (XW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (in_xfer),
        .i_rd_addr (x_in),
        .i_wr_en   (adv1),
        .i_wr_addr (r_x1),
        .i_wr_up   (lb_mid),
        .i_wr_mid  (r_px1),
        .o_rd_up   (lb_up),
        .o_rd_mid  (lb_mid)
    );

    // Region test for the centre this pixel completes
    logic [XW-1:0] cx1;
    logic [YW-1:0] cy1;
    logic          inside1;

    assign cx1     = r_x1 - XW'(1);
    assign cy1     = r_y1 - YW'(1);
    assign inside1 = (CW'(cx1) > CW'(r_rxs)) && (CW'(cx1) + CW'(1) < CW'(r_rxe)) &&
                     (CW'(cy1) > CW'(r_rys)) && (CW'(cy1) + CW'(1) < CW'(r_rye)) &&
                     (r_ksel <= KS_SOBEL_Y);

    // ---------------- stage 2: window ----------------
    logic [PX_W-1:0] r_win [WIN_N];
    logic [XW-1:0]   r_cx2;
    logic [YW-1:0]   r_cy2;
    logic            r_in2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv1) begin
            r_v2 <= r_emit1;
        end else if (adv2) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]     <= r_win[r*3 + 1];
                r_win[r*3 + 1] <= r_win[r*3 + 2];
            end
            r_win[2] <= lb_up;
            r_win[5] <= lb_mid;
            r_win[8] <= r_px1;
            r_cx2    <= cx1;
            r_cy2    <= cy1;
            r_in2    <= inside1;
        end
    end

    // ---------------- stage 3 and output ----------------
    logic [XW-1:0] r_cx3, r_cxo;
    logic [YW-1:0] r_cy3, r_cyo;
    logic          r_in3, r_ino;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (adv2) begin
                r_v3 <= 1'b1;
            end else if (adv3) begin
                r_v3 <= 1'b0;
            end
            if (adv3) begin
                r_vo <= 1'b1;
            end else if (out_take) begin
                r_vo <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_cx3 <= r_cx2;
            r_cy3 <= r_cy2;
            r_in3 <= r_in2;
        end
        if (adv3) begin
            r_cxo <= r_cx3;
            r_cyo <= r_cy3;
            r_ino <= r_in3;
        end
    end

    // Per-channel kernel datapath
    t_chan_ctl       chan_ctl;
    logic [CH_W-1:0] chan_pix [NUM_CH];

    assign chan_ctl.ld_sum = adv2;
    assign chan_ctl.ld_out = adv3;
    assign chan_ctl.in_roi = r_in2;
    assign chan_ctl.sel    = r_ksel;

    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        t_win_chan win_c;

        always_comb begin
            for (int i = 0; i < WIN_N; i++) begin
                win_c[i] = r_win[i][PX_W-1-CH_W*c -: CH_W];
            end
        end

        c3ksf_chan u_chan (
            .i_clk (i_clk),
            .i_ctl (chan_ctl),
            .i_win (win_c),
            .o_pix (chan_pix[c])
        );
    end

    assign o_valid        = r_vo;
    assign o_out_red      = chan_pix[0];
    assign o_out_green    = chan_pix[1];
    assign o_out_blue     = chan_pix[2];
    assign o_centre_x     = POS_W'(r_cxo);
    assign o_centre_y     = POS_W'(r_cyo);
    assign o_was_filtered = r_ino;

endmodule

// ----- hdl/c3ksf_checker.sv -----
module c3ksf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_red,
    input logic [7:0] o_out_green,
    input logic [7:0] o_out_blue,
    input logic [9:0] o_centre_x,
    input logic [9:0] o_centre_y,
    input logic       o_was_filtered
);

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_red) && $stable(o_out_green) &&
            $stable(o_out_blue) && $stable(o_centre_x) && $stable(o_centre_y) &&
            $stable(o_was_filtered))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    // input back-pressure only from a stalled, full output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    // a full pipeline stays full, so next cycle the input stall follows the output stall
    a_stall_persist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> (o_stall == i_stall))
        else $error("input stall out of step with output stall on a full pipeline");

endmodule

bind conv3x3_kernel_select_filter_core c3ksf_checker u_c3ksf_checker (.*);
